// ===== rtl/fcbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Feistel CBC cipher package
// Shared types, constants and functions for the Feistel CBC block cipher.
// ----------------------------------------------------------------------------
package fcbc_pkg;

   localparam int ROUNDS = 16;
   localparam int RIDX_W = $clog2(ROUNDS);

   localparam logic [31:0] START_KEY = 32'h9e3779b9;
   localparam logic [31:0] STEP_KEY  = 32'h7f4a7c15;
   localparam logic [31:0] MIX_KEY   = 32'hA5A5A5A5;
   localparam logic [63:0] BYTE_ONES = 64'h0101010101010101;

   localparam logic [2:0] OP_KEY_BYTE = 3'd0;
   localparam logic [2:0] OP_FINISH   = 3'd1;
   localparam logic [2:0] OP_LOAD_IV  = 3'd2;
   localparam logic [2:0] OP_ENCRYPT  = 3'd3;
   localparam logic [2:0] OP_DECRYPT  = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_PAD = 2'd1;
   localparam logic [1:0] ST_NO_KEY  = 2'd2;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  key_byte;
      logic [63:0] data;
      logic [3:0]  byte_count;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [63:0] result_block;
      logic [3:0]  valid_bytes;
      logic        final_result;
      logic [1:0]  status;
   } rsp_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
      logic [63:0] d;
      begin
         d = {x, x} << s;
         rotl = d[63:32];
      end
   endfunction

   function automatic logic [31:0] start_key(input logic [RIDX_W-1:0] r);
      logic [31:0] p;
      begin
         p = 32'(r) * STEP_KEY;
         start_key = START_KEY + p;
      end
   endfunction

   function automatic logic [31:0] mix(input logic [31:0] half, input logic [31:0] rk);
      logic [31:0] x;
      begin
         x = half + rk;
         x = x ^ rotl(half, 5'd5);
         x = x + (rk ^ MIX_KEY);
         x = rotl(x, 5'd11);
         mix = x ^ (rk >> 3);
      end
   endfunction

   function automatic logic [7:0] fallback_byte(input logic [2:0] j);
      logic [7:0] b;
      begin
         case (j)
            3'd0: b = 8'h64;
            3'd1: b = 8'h65;
            3'd2: b = 8'h66;
            3'd3: b = 8'h61;
            3'd4: b = 8'h75;
            3'd5: b = 8'h6c;
            default: b = 8'h74;
         endcase
         fallback_byte = b;
      end
   endfunction

endpackage

// ===== rtl/fcbc_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one request transaction.
// ----------------------------------------------------------------------------
interface fcbc_req_if;
   logic                  valid;
   logic                  ready;
   fcbc_pkg::req_type     payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/fcbc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying one response transaction.
// ----------------------------------------------------------------------------
interface fcbc_rsp_if;
   logic                  valid;
   logic                  ready;
   fcbc_pkg::rsp_type     payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/fcbc_front.sv =====
// ----------------------------------------------------------------------------
// Request front end
// Two-entry queue that accepts request transactions and holds them for the
// engine.
// ----------------------------------------------------------------------------
module fcbc_front (
   input  logic              clock,
   input  logic              reset,
   fcbc_req_if.sink          req,
   output fcbc_pkg::req_type head,
   output logic              head_valid,
   input  logic              head_pop
);
   fcbc_pkg::req_type q_ff [2];
   logic              wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push;

   assign req.ready  = (cnt_ff != 2'd2);
   assign push       = req.valid && req.ready;
   assign head       = q_ff[rp_ff];
   assign head_valid = (cnt_ff != 2'd0);

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ (head_pop && head_valid);
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, head_pop && head_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wp_ff] <= req.payload;
   end
endmodule

// ===== rtl/fcbc_engine.sv =====
// ----------------------------------------------------------------------------
// Cipher engine
// Sequencer for key schedule, one Feistel round per cycle, CBC chaining and
// padding, with a response output register.
// ----------------------------------------------------------------------------
module fcbc_engine (
   input  logic              clock,
   input  logic              reset,
   input  fcbc_pkg::req_type head,
   input  logic              head_valid,
   output logic              head_pop,
   fcbc_rsp_if.source        rsp
);
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ABSORB = 3'd1;
   localparam logic [2:0] S_FINISH = 3'd2;
   localparam logic [2:0] S_ROUND  = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   localparam int RW = fcbc_pkg::RIDX_W;

   logic [2:0]      state_ff, state_in;
   logic [31:0]     rk_ff [fcbc_pkg::ROUNDS];
   logic [15:0]     klen_ff, klen_in;
   logic            kready_ff, kready_in;
   logic [63:0]     chain_ff, chain_in;
   logic [RW-1:0]   idx_ff, idx_in;
   logic [2:0]      fb_ff, fb_in;
   logic            fb_mode_ff, fb_mode_in;
   logic [7:0]      absorb_byte_ff, absorb_byte_in;
   logic [31:0]     l_ff, l_in, r_ff, r_in;
   logic            dec_ff, dec_in, last_ff, last_in, extra_ff, extra_in;
   logic [63:0]     cin_ff, cin_in;
   logic            ov_ff, ov_in;
   fcbc_pkg::rsp_type out_ff, out_in;

   logic [31:0]     rk_cur, rk_wr, rk_mul;
   logic            rk_we, rk_clear;
   logic            out_free;
   logic [3:0]      nsat;
   logic [63:0]     keep, plain, fin_blk, dplain, pmask;
   logic [7:0]      pad;
   logic            pad_bad;
   logic [31:0]     fmul;

   assign out_free  = !ov_ff || rsp.ready;
   assign rsp.valid = ov_ff;
   assign rsp.payload = out_ff;
   assign rk_cur    = rk_ff[idx_ff];
   assign rk_mul    = rk_cur * 32'd31;
   assign fmul      = 32'(klen_ff) * 32'({1'b0, idx_ff} + 1);

   always_comb begin
      nsat = (head.byte_count > 4'd8) ? 4'd8 : head.byte_count;
      keep = (nsat == 4'd0) ? 64'd0 : ~(64'hFFFFFFFFFFFFFFFF >> (7'd8 * 7'(nsat)));
      plain = head.data;
      if (head.last && nsat < 4'd8)
         plain = (head.data & keep) | ((64'(4'd8 - nsat) * fcbc_pkg::BYTE_ONES) & ~keep);
      fin_blk = {l_ff, r_ff};
      dplain = fin_blk ^ cin_ff;
      pad = dplain[7:0];
      pmask = (pad >= 8'd8) ? 64'hFFFFFFFFFFFFFFFF : ~(64'hFFFFFFFFFFFFFFFF << (pad[2:0] * 6'd8));
      pad_bad = (pad == 8'd0) || (pad > 8'd8) ||
                ((dplain & pmask) != ((64'(pad) * fcbc_pkg::BYTE_ONES) & pmask));
   end

   always_comb begin
      state_in = state_ff; klen_in = klen_ff; kready_in = kready_ff;
      chain_in = chain_ff; idx_in = idx_ff; fb_in = fb_ff; fb_mode_in = fb_mode_ff;
      absorb_byte_in = absorb_byte_ff; l_in = l_ff; r_in = r_ff;
      dec_in = dec_ff; last_in = last_ff; extra_in = extra_ff; cin_in = cin_ff;
      ov_in = ov_ff && !rsp.ready; out_in = out_ff;
      head_pop = 1'b0; rk_we = 1'b0; rk_wr = rk_cur; rk_clear = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               case (head.operation)
                  fcbc_pkg::OP_KEY_BYTE: begin
                     head_pop = 1'b1;
                     if (kready_ff) begin
                        rk_clear = 1'b1; klen_in = 16'd0; kready_in = 1'b0;
                     end
                     absorb_byte_in = head.key_byte; fb_mode_in = 1'b0;
                     idx_in = '0; state_in = S_ABSORB;
                  end
                  fcbc_pkg::OP_FINISH: begin
                     head_pop = 1'b1;
                     if (!kready_ff) begin
                        idx_in = '0;
                        if (klen_ff == 16'd0) begin
                           fb_mode_in = 1'b1; fb_in = 3'd0;
                           absorb_byte_in = fcbc_pkg::fallback_byte(3'd0);
                           state_in = S_ABSORB;
                        end else state_in = S_FINISH;
                     end
                  end
                  fcbc_pkg::OP_LOAD_IV: begin
                     head_pop = 1'b1; chain_in = head.data;
                  end
                  fcbc_pkg::OP_ENCRYPT, fcbc_pkg::OP_DECRYPT: begin
                     if (!kready_ff) begin
                        if (out_free) begin
                           head_pop = 1'b1; ov_in = 1'b1;
                           out_in = '{64'd0, 4'd0, head.last, fcbc_pkg::ST_NO_KEY};
                        end
                     end else begin
                        head_pop = 1'b1; idx_in = '0;
                        last_in = head.last;
                        if (head.operation == fcbc_pkg::OP_ENCRYPT) begin
                           dec_in = 1'b0;
                           extra_in = head.last && (nsat == 4'd8);
                           {l_in, r_in} = plain ^ chain_ff;
                           idx_in = '0;
                        end else begin
                           dec_in = 1'b1; extra_in = 1'b0;
                           {l_in, r_in} = head.data;
                           cin_in = chain_ff; chain_in = head.data;
                           idx_in = RW'(fcbc_pkg::ROUNDS - 1);
                        end
                        state_in = S_ROUND;
                     end
                  end
                  default: head_pop = 1'b1;
               endcase
            end
         end
         S_ABSORB: begin
            rk_we = 1'b1;
            rk_wr = fcbc_pkg::rotl(rk_mul + 32'(absorb_byte_ff),
                                   5'(klen_ff) + 5'(idx_ff));
            idx_in = idx_ff + 1'b1;
            if (idx_ff == RW'(fcbc_pkg::ROUNDS - 1)) begin
               if (klen_ff != 16'hFFFF) klen_in = klen_ff + 16'd1;
               idx_in = '0;
               if (fb_mode_ff && fb_ff != 3'd6) begin
                  fb_in = fb_ff + 3'd1;
                  absorb_byte_in = fcbc_pkg::fallback_byte(fb_ff + 3'd1);
               end else if (fb_mode_ff) state_in = S_FINISH;
               else state_in = S_IDLE;
            end
         end
         S_FINISH: begin
            rk_we = 1'b1; rk_wr = rk_cur ^ fmul;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == RW'(fcbc_pkg::ROUNDS - 1)) begin
               kready_in = 1'b1; state_in = S_IDLE;
            end
         end
         S_ROUND: begin
            if (dec_ff) begin
               l_in = r_ff ^ fcbc_pkg::mix(l_ff, rk_cur); r_in = l_ff;
               idx_in = idx_ff - 1'b1;
               if (idx_ff == '0) state_in = S_DONE;
            end else begin
               l_in = r_ff; r_in = l_ff ^ fcbc_pkg::mix(r_ff, rk_cur);
               idx_in = idx_ff + 1'b1;
               if (idx_ff == RW'(fcbc_pkg::ROUNDS - 1)) state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               ov_in = 1'b1;
               if (dec_ff) begin
                  if (!last_ff) out_in = '{dplain, 4'd8, 1'b0, fcbc_pkg::ST_OK};
                  else if (pad_bad) out_in = '{64'd0, 4'd0, 1'b1, fcbc_pkg::ST_BAD_PAD};
                  else out_in = '{dplain & ~pmask, 4'd8 - pad[3:0], 1'b1, fcbc_pkg::ST_OK};
                  state_in = S_IDLE;
               end else begin
                  chain_in = fin_blk;
                  out_in = '{fin_blk, 4'd8, last_ff && !extra_ff, fcbc_pkg::ST_OK};
                  if (extra_ff) begin
                     extra_in = 1'b0;
                     {l_in, r_in} = (64'd8 * fcbc_pkg::BYTE_ONES) ^ fin_blk;
                     idx_in = '0; state_in = S_ROUND;
                  end else state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; klen_ff <= 16'd0; kready_ff <= 1'b0;
         chain_ff <= 64'd0; ov_ff <= 1'b0; idx_ff <= '0;
         fb_ff <= 3'd0; fb_mode_ff <= 1'b0;
         for (int i = 0; i < fcbc_pkg::ROUNDS; i++) rk_ff[i] <= fcbc_pkg::start_key(RW'(i));
      end else begin
         state_ff <= state_in; klen_ff <= klen_in; kready_ff <= kready_in;
         chain_ff <= chain_in; ov_ff <= ov_in; idx_ff <= idx_in;
         fb_ff <= fb_in; fb_mode_ff <= fb_mode_in;
         if (rk_clear)
            for (int i = 0; i < fcbc_pkg::ROUNDS; i++) rk_ff[i] <= fcbc_pkg::start_key(RW'(i));
         else if (rk_we) rk_ff[idx_ff] <= rk_wr;
      end
      absorb_byte_ff <= absorb_byte_in; l_ff <= l_in; r_ff <= r_in;
      dec_ff <= dec_in; last_ff <= last_in; extra_ff <= extra_in;
      cin_ff <= cin_in; out_ff <= out_in;
   end
endmodule

// ===== rtl/feistel_cbc_block_cipher.sv =====
// ----------------------------------------------------------------------------
// Feistel CBC block cipher
// 64-bit, 16-round Feistel cipher with CBC chaining and PKCS7 padding.
// ----------------------------------------------------------------------------
// Request transactions carry an operation: key byte, finish key, load IV,
// encrypt block or decrypt block. Response transactions carry a result block,
// its valid byte count, a final flag and a status.
// A two-entry request queue decouples the input from the engine.
// A key byte leaves the queue and is then mixed into each round-key
// accumulator in turn. Finish, while the key is not ready, folds the key
// length into each accumulator, after absorbing a default key if none was
// given. With a finished key, an encrypt or decrypt block leaves the queue,
// runs the 16 Feistel rounds and loads the response register once it is
// free; without a finished key, the block gets a no-key status response.
// A full last encrypt block runs a second pass for the pad block.
// The round loop, one Feistel round per cycle, sets the throughput.
// Reset clears the key, the chain block and the queue; the round keys
// return to their start constants at once.
// When the receiver stalls, the response register holds its transaction and
// the engine waits when it has another response to load; the queue keeps accepting until it is full.
// ----------------------------------------------------------------------------
module feistel_cbc_block_cipher (
   input  logic       clock,
   input  logic       reset,
   fcbc_req_if.sink   req,
   fcbc_rsp_if.source rsp
);
   fcbc_pkg::req_type head;
   logic              head_valid;
   logic              head_pop;

   fcbc_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .head(head), .head_valid(head_valid), .head_pop(head_pop)
   );

   fcbc_engine u_engine (
      .clock(clock), .reset(reset), .head(head), .head_valid(head_valid),
      .head_pop(head_pop), .rsp(rsp)
   );

`ifndef SYNTH
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid) else $error("pop from empty queue");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.payload.status != 2'd3) else $error("bad status code");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.payload.status != fcbc_pkg::ST_OK) |->
      (rsp.payload.result_block == 64'd0 && rsp.payload.valid_bytes == 4'd0))
      else $error("error response with data");
`endif
endmodule
